// ===== src/sccb_master_bit_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// SCCB bit sequencer assertion macros
// Shorthand for clocked assertions, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCCB_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH
`define SCCB_MASTER_BIT_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sccb_bs_pkg.sv =====
// ----------------------------------------------------------------------------
// SCCB bit sequencer package
// Command codes, widths and tick positions shared by the sequencer and its channels.
// ----------------------------------------------------------------------------
package sccb_bs_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned TICK_W = 5;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_READ  = 3'd3,
    MODE_ACK   = 3'd4,
    MODE_NACK  = 3'd5,
    MODE_IDLE  = 3'd7
  } mode_t;

  // Index of the final tick of each command
  localparam logic [TICK_W-1:0] LAST_START = 5'd3;
  localparam logic [TICK_W-1:0] LAST_STOP  = 5'd2;
  localparam logic [TICK_W-1:0] LAST_WRITE = 5'd27;
  localparam logic [TICK_W-1:0] LAST_READ  = 5'd24;
  localparam logic [TICK_W-1:0] LAST_ACK   = 5'd3;

  // Write byte: data slots end here, then the ack slot ticks
  localparam logic [TICK_W-1:0] WR_DATA_END = 5'd24;
  localparam logic [TICK_W-1:0] WR_RELEASE  = 5'd25;
  localparam logic [TICK_W-1:0] WR_SAMPLE   = 5'd26;

  // Phase within one three-tick bit slot
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;

endpackage

// ===== src/sccb_bs_if.sv =====
// ----------------------------------------------------------------------------
// SCCB bit sequencer channels
// Valid/ready channels for tick items in and line-state results out.
// ----------------------------------------------------------------------------
interface sccb_bs_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd_valid;
  logic [sccb_bs_pkg::MODE_W-1:0]     mode;
  logic [sccb_bs_pkg::BYTE_W-1:0]     tx_byte;
  logic                               sda_in;

  modport source (output valid, cmd_valid, mode, tx_byte, sda_in, input ready);
  modport sink   (input valid, cmd_valid, mode, tx_byte, sda_in, output ready);
endinterface

interface sccb_bs_out_if;
  logic                               valid;
  logic                               ready;
  logic                               scl;
  logic                               sda_out;
  logic                               sda_oe;
  logic                               busy_res;
  logic                               done_res;
  logic [sccb_bs_pkg::BYTE_W-1:0]     rx_byte;
  logic                               ack_bit;

  modport source (output valid, scl, sda_out, sda_oe, busy_res, done_res, rx_byte,
                  ack_bit, input ready);
  modport sink   (input valid, scl, sda_out, sda_oe, busy_res, done_res, rx_byte,
                  ack_bit, output ready);
endinterface

// ===== src/sccb_master_bit_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// SCCB master bit sequencer
// Plays start, stop, write byte, read byte, ack and nack as fixed tick
// sequences on SCL/SDA, one tick per input transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                         Handshake
//  in_ch     sink       cmd_valid, mode, tx_byte, sda_in                valid/ready
//  out_ch    source     scl, sda_out, sda_oe, busy_res, done_res,       valid/ready
//                       rx_byte, ack_bit
//
//  One tick transaction in gives one registered result transaction out in the next cycle.
//  A tick is taken every cycle unless out_ch stalls; the limit is the single
//  output register, which frees in the cycle its result is taken.
//  in_ch.ready drops only while the output register is full and out_ch is stalled.
//  Reset (rst_n, synchronous) idles the sequencer with SCL low and SDA driven high.
//
`include "sccb_master_bit_sequencer_unit_assert.svh"

module sccb_master_bit_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  sccb_bs_in_if.sink           in_ch,
  sccb_bs_out_if.source        out_ch
);

  // Sequencer state
  sccb_bs_pkg::mode_t                   mode_r, mode_nxt;
  logic [sccb_bs_pkg::TICK_W-1:0]       tick_r, tick_nxt;
  logic [1:0]                           ph_r, ph_nxt;
  logic [sccb_bs_pkg::BYTE_W-1:0]       shift_r, shift_nxt;
  logic [sccb_bs_pkg::BYTE_W-1:0]       tx_r, tx_nxt;
  logic                                 ack_r, ack_nxt;
  logic                                 scl_r, scl_nxt;
  logic                                 sda_r, sda_nxt;
  logic                                 oe_r, oe_nxt, oe_state_nxt;

  // Result register
  logic                                 out_valid_r;
  logic                                 res_scl_r, res_sda_r, res_oe_r;
  logic                                 res_busy_r, res_done_r, res_ack_r;
  logic [sccb_bs_pkg::BYTE_W-1:0]       res_rx_r;

  // Tick working values
  logic                                 accept;
  logic                                 start;
  sccb_bs_pkg::mode_t                   eff_mode;
  logic [sccb_bs_pkg::TICK_W-1:0]       eff_tick;
  logic [1:0]                           eff_ph;
  logic [sccb_bs_pkg::BYTE_W-1:0]       eff_tx;
  logic [sccb_bs_pkg::TICK_W-1:0]       last_tick;
  logic                                 busy;
  logic                                 done;

  // The output register parts the two sides: take a tick whenever it is free
  // or being emptied in this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // A command launches only from idle, and only with a defined code; it plays
  // its first tick in the same transaction.
  assign start = (mode_r == sccb_bs_pkg::MODE_IDLE) && in_ch.cmd_valid &&
                 (in_ch.mode <= sccb_bs_pkg::MODE_NACK);

  assign eff_mode = start ? sccb_bs_pkg::mode_t'(in_ch.mode) : mode_r;
  assign eff_tick = start ? '0 : tick_r;
  assign eff_ph   = start ? sccb_bs_pkg::PH_SETUP : ph_r;
  assign eff_tx   = start ? in_ch.tx_byte : tx_r;
  assign busy     = (eff_mode != sccb_bs_pkg::MODE_IDLE);

  always_comb begin
    unique case (eff_mode)
      sccb_bs_pkg::MODE_START: last_tick = sccb_bs_pkg::LAST_START;
      sccb_bs_pkg::MODE_STOP:  last_tick = sccb_bs_pkg::LAST_STOP;
      sccb_bs_pkg::MODE_WRITE: last_tick = sccb_bs_pkg::LAST_WRITE;
      sccb_bs_pkg::MODE_READ:  last_tick = sccb_bs_pkg::LAST_READ;
      default:                 last_tick = sccb_bs_pkg::LAST_ACK;
    endcase
  end

  assign done = busy && (eff_tick >= last_tick);

  // Line levels and data registers for this tick
  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    oe_nxt    = oe_r;
    shift_nxt = shift_r;
    ack_nxt   = ack_r;
    tx_nxt    = eff_tx;

    unique case (eff_mode)
      sccb_bs_pkg::MODE_START: begin
        if (eff_tick == 5'd0) begin
          sda_nxt = 1'b1;
          oe_nxt  = 1'b1;
        end else if (eff_tick == 5'd1) begin
          scl_nxt = 1'b1;
        end else if (eff_tick == 5'd2) begin
          sda_nxt = 1'b0;
        end else begin
          scl_nxt = 1'b0;
        end
      end
      sccb_bs_pkg::MODE_STOP: begin
        if (eff_tick == 5'd0) begin
          sda_nxt = 1'b0;
          oe_nxt  = 1'b1;
        end else if (eff_tick == 5'd1) begin
          scl_nxt = 1'b1;
        end else begin
          sda_nxt = 1'b1;
        end
      end
      sccb_bs_pkg::MODE_ACK: begin
        if (eff_tick == 5'd0) begin
          sda_nxt = 1'b0;
          oe_nxt  = 1'b1;
        end else if (eff_tick == 5'd1) begin
          scl_nxt = 1'b1;
        end else if (eff_tick == 5'd2) begin
          scl_nxt = 1'b0;
        end else begin
          oe_nxt = 1'b0;
        end
      end
      sccb_bs_pkg::MODE_NACK: begin
        if (eff_tick == 5'd0) begin
          sda_nxt = 1'b1;
          oe_nxt  = 1'b0;
        end else if (eff_tick == 5'd1) begin
          scl_nxt = 1'b1;
        end else if (eff_tick == 5'd2) begin
          scl_nxt = 1'b0;
        end else begin
          sda_nxt = 1'b0;
        end
      end
      sccb_bs_pkg::MODE_WRITE: begin
        if (eff_tick < sccb_bs_pkg::WR_DATA_END) begin
          // MSB sits at the top of the latch; advance it after each bit slot
          if (eff_ph == sccb_bs_pkg::PH_SETUP) begin
            sda_nxt = eff_tx[sccb_bs_pkg::BYTE_W-1];
            oe_nxt  = 1'b1;
          end else if (eff_ph == sccb_bs_pkg::PH_HIGH) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
            tx_nxt  = {eff_tx[sccb_bs_pkg::BYTE_W-2:0], 1'b0};
          end
        end else if (eff_tick == sccb_bs_pkg::WR_RELEASE) begin
          oe_nxt = 1'b0;
        end else if (eff_tick == sccb_bs_pkg::WR_SAMPLE) begin
          scl_nxt = 1'b1;
          ack_nxt = in_ch.sda_in;
        end else if (eff_tick == sccb_bs_pkg::LAST_WRITE) begin
          scl_nxt = 1'b0;
        end
      end
      sccb_bs_pkg::MODE_READ: begin
        // Bit slots start one tick late, so the phase counter runs one ahead
        if (eff_tick == 5'd0) begin
          oe_nxt    = 1'b0;
          shift_nxt = '0;
        end else if (eff_ph == sccb_bs_pkg::PH_LOW) begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[sccb_bs_pkg::BYTE_W-2:0], in_ch.sda_in};
        end else if (eff_ph == sccb_bs_pkg::PH_SETUP) begin
          scl_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence position
  always_comb begin
    mode_nxt     = eff_mode;
    tick_nxt     = eff_tick;
    ph_nxt       = eff_ph;
    oe_state_nxt = oe_nxt;
    if (done) begin
      mode_nxt = sccb_bs_pkg::MODE_IDLE;
      tick_nxt = '0;
      ph_nxt   = sccb_bs_pkg::PH_SETUP;
      // A write hands the bus back driven once its result is reported
      if (eff_mode == sccb_bs_pkg::MODE_WRITE) begin
        oe_state_nxt = 1'b1;
      end
    end else if (busy) begin
      tick_nxt = eff_tick + 5'd1;
      ph_nxt   = (eff_ph == sccb_bs_pkg::PH_LOW) ? sccb_bs_pkg::PH_SETUP : eff_ph + 2'd1;
    end
  end

  // Advance state once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= sccb_bs_pkg::MODE_IDLE;
      tick_r  <= '0;
      ph_r    <= sccb_bs_pkg::PH_SETUP;
      shift_r <= '0;
      tx_r    <= '0;
      ack_r   <= 1'b0;
      scl_r   <= 1'b0;
      sda_r   <= 1'b1;
      oe_r    <= 1'b1;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      tick_r  <= tick_nxt;
      ph_r    <= ph_nxt;
      shift_r <= shift_nxt;
      tx_r    <= tx_nxt;
      ack_r   <= ack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      oe_r    <= oe_state_nxt;
    end
  end

  // Result register: hold while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_scl_r  <= scl_nxt;
      res_sda_r  <= sda_nxt;
      res_oe_r   <= oe_nxt;
      res_busy_r <= busy;
      res_done_r <= done;
      res_rx_r   <= shift_nxt;
      res_ack_r  <= ack_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.scl      = res_scl_r;
  assign out_ch.sda_out  = res_sda_r;
  assign out_ch.sda_oe   = res_oe_r;
  assign out_ch.busy_res = res_busy_r;
  assign out_ch.done_res = res_done_r;
  assign out_ch.rx_byte  = res_rx_r;
  assign out_ch.ack_bit  = res_ack_r;

  // Checks
  `SBS_ASSERT_NOW(a_idle_tick_zero, mode_r == sccb_bs_pkg::MODE_IDLE, tick_r == '0 && ph_r == sccb_bs_pkg::PH_SETUP, "idle sequencer holds a nonzero tick position")
  `SBS_ASSERT_NOW(a_tick_in_range, mode_r != sccb_bs_pkg::MODE_IDLE, tick_r <= last_tick && ph_r != 2'd3, "tick position beyond the end of the command")
  `SBS_ASSERT_NEXT(a_done_goes_idle, accept && done, mode_r == sccb_bs_pkg::MODE_IDLE && out_ch.done_res && out_ch.busy_res, "finished command did not return to idle")
  `SBS_ASSERT_NEXT(a_write_restores_oe, accept && done && eff_mode == sccb_bs_pkg::MODE_WRITE, oe_r && !out_ch.sda_oe, "write did not hand SDA back driven")
  `SBS_ASSERT_NEXT(a_result_follows_tick, accept, out_ch.valid, "accepted tick produced no result")

endmodule
